// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== design/rdmc_pkg.sv =====
// Shared constants and types of the ring distance clusterer.
package rdmc_pkg;
  localparam int RING_COUNT = 7;
  localparam int CLUSTERS_PER_RING = 32;
  localparam int RING_W = 3;
  localparam int IDX_W = (CLUSTERS_PER_RING > 1) ? $clog2(CLUSTERS_PER_RING) : 1;
  localparam int USED_W = $clog2(CLUSTERS_PER_RING + 1);
  localparam int TOL_W = 20;
  localparam logic [15:0] HITS_MAX = 16'hFFFF;
  localparam logic CFG_BASE_TOL = 1'b0;
  localparam logic CFG_GROWTH = 1'b1;
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  // Search or report token that walks the row of cells.
  typedef struct packed {
    logic               valid;
    logic               report;
    logic [RING_W-1:0]  ring;
    logic [15:0]        point;
    logic [TOL_W-1:0]   tol;
    logic [USED_W-1:0]  used;
    logic               found;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        fsum;
    logic [15:0]        fhits;
    logic [15:0]        bhits;
    logic [15:0]        bmean;
  } tok_t;

  // Entry update broadcast to all cells.
  typedef struct packed {
    logic               en;
    logic [RING_W-1:0]  ring;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        sum;
    logic [15:0]        hits;
    logic [15:0]        mean;
  } wr_t;
endpackage

// ===== design/rdmc_div.sv =====
// Restoring divider, one quotient bit per cycle: 32-bit sum over 16-bit count.
module rdmc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  logic        busy;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [31:0] quo;
  logic [15:0] dvs;
  logic [16:0] trial;
  logic        ge;

  assign trial = {rem, quo[31]};
  assign ge = trial >= {1'b0, dvs};
  assign quotient = quo[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (busy) begin
        rem <= ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
        quo <= {quo[30:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== design/rdmc_cell.sv =====
// One cluster slot for every ring; matches or ranks the passing token.
module rdmc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rdmc_pkg::IDX_W-1:0] cell_idx,
  input  rdmc_pkg::tok_t            tok_in,
  input  rdmc_pkg::wr_t             wr,
  output rdmc_pkg::tok_t            tok_out
);
  logic [31:0] sum_q  [rdmc_pkg::RING_COUNT];
  logic [15:0] hits_q [rdmc_pkg::RING_COUNT];
  logic [15:0] mean_q [rdmc_pkg::RING_COUNT];
  logic [31:0] cur_sum;
  logic [15:0] cur_hits;
  logic [15:0] cur_mean;
  logic [15:0] diff;
  logic        live;
  rdmc_pkg::tok_t tok_next;

  always_comb begin
    cur_sum = sum_q[tok_in.ring];
    cur_hits = hits_q[tok_in.ring];
    cur_mean = mean_q[tok_in.ring];
    diff = (cur_mean > tok_in.point) ? cur_mean - tok_in.point : tok_in.point - cur_mean;
    live = tok_in.valid && ({1'b0, cell_idx} < tok_in.used);
    tok_next = tok_in;
    if (live) begin
      if (tok_in.report) begin
        if (cur_hits > tok_in.bhits) begin
          tok_next.bhits = cur_hits;
          tok_next.bmean = cur_mean;
        end
      end else if (!tok_in.found && ({4'd0, diff} <= tok_in.tol)) begin
        tok_next.found = 1'b1;
        tok_next.idx = cell_idx;
        tok_next.fsum = cur_sum;
        tok_next.fhits = cur_hits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.report <= tok_next.report;
    tok_out.ring <= tok_next.ring;
    tok_out.point <= tok_next.point;
    tok_out.tol <= tok_next.tol;
    tok_out.used <= tok_next.used;
    tok_out.found <= tok_next.found;
    tok_out.idx <= tok_next.idx;
    tok_out.fsum <= tok_next.fsum;
    tok_out.fhits <= tok_next.fhits;
    tok_out.bhits <= tok_next.bhits;
    tok_out.bmean <= tok_next.bmean;
    if (wr.en && wr.idx == cell_idx) begin
      sum_q[wr.ring] <= wr.sum;
      hits_q[wr.ring] <= wr.hits;
      mean_q[wr.ring] <= wr.mean;
    end
  end
endmodule

// ===== design/ring_distance_mode_clusterer.sv =====
// Top level of the ring distance clusterer: control, registers and cell row.
// One item at a time. An insert walks a token through the row of
// CLUSTERS_PER_RING cells, one cell per cycle; when an existing cluster
// grows, its new mean comes from a bit-serial divider. End of frame walks
// one token per ring through the row and delivers one transaction per ring,
// holding while the output stalls. The occupancy counts and overflow flags
// clear at once after the last report line is taken; no clearing pass is
// needed.
`include "assert_macros.svh"
module ring_distance_mode_clusterer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [2:0]  ring,
  input  logic [15:0] distance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  ring_id,
  output logic [15:0] mean_distance,
  output logic [15:0] hits,
  output logic        overflowed,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  typedef enum logic [2:0] {S_IDLE, S_TOL, S_LAUNCH, S_WAIT, S_DIV, S_OUT} state_t;

  localparam int RC = rdmc_pkg::RING_COUNT;
  localparam int CPR = rdmc_pkg::CLUSTERS_PER_RING;

  state_t state;
  logic [15:0] base_tol;
  logic [7:0]  growth;
  logic [rdmc_pkg::USED_W-1:0] used_q [RC];
  logic [RC-1:0] drop_q;
  logic        report_q;
  logic [2:0]  ring_q;
  logic [15:0] dist_q;
  logic [rdmc_pkg::TOL_W-1:0] tol_q;
  logic [rdmc_pkg::IDX_W-1:0] idx_q;
  logic [31:0] nsum_q;
  logic [15:0] nhits_q;
  logic        div_start;
  logic        div_done;
  logic [15:0] div_quo;
  logic [11:0] factor;
  logic [27:0] tol_prod;
  rdmc_pkg::wr_t  wr_q;
  rdmc_pkg::tok_t chain [CPR+1];
  rdmc_pkg::tok_t tail;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign factor = 12'd256 + 12'(growth) * 12'(ring_q);
  assign tol_prod = 28'(base_tol) * 28'(factor);
  assign tail = chain[CPR];

  always_comb begin
    chain[0] = '0;
    chain[0].valid = (state == S_LAUNCH);
    chain[0].report = report_q;
    chain[0].ring = ring_q;
    chain[0].point = dist_q;
    chain[0].tol = tol_q;
    chain[0].used = used_q[ring_q];
  end

  for (genvar k = 0; k < CPR; k++) begin : g_cell
    rdmc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (rdmc_pkg::IDX_W'(k)),
      .tok_in   (chain[k]),
      .wr       (wr_q),
      .tok_out  (chain[k+1])
    );
  end

  rdmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (nsum_q),
    .divisor  (nhits_q),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      base_tol <= 16'd128;
      growth <= 8'd77;
      drop_q <= '0;
      ring_q <= '0;
      for (int i = 0; i < RC; i++) used_q[i] <= '0;
      out_valid <= 1'b0;
      wr_q.en <= 1'b0;
      div_start <= 1'b0;
    end else begin
      wr_q.en <= 1'b0;
      div_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rdmc_pkg::CFG_BASE_TOL) base_tol <= cfg_data;
        else growth <= cfg_data[7:0];
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            dist_q <= distance;
            if (func == rdmc_pkg::FUNC_REPORT) begin
              report_q <= 1'b1;
              ring_q <= '0;
              state <= S_LAUNCH;
            end else if (32'(ring) < RC) begin
              report_q <= 1'b0;
              ring_q <= ring;
              state <= S_TOL;
            end
          end
        end
        S_TOL: begin
          tol_q <= tol_prod[27:8];
          state <= S_LAUNCH;
        end
        S_LAUNCH: state <= S_WAIT;
        S_WAIT: begin
          if (tail.valid) begin
            if (tail.report) begin
              out_valid <= 1'b1;
              ring_id <= ring_q;
              mean_distance <= tail.bmean;
              hits <= tail.bhits;
              overflowed <= drop_q[ring_q];
              last <= (32'(ring_q) == RC - 1);
              state <= S_OUT;
            end else if (tail.found) begin
              if (tail.fhits != rdmc_pkg::HITS_MAX) begin
                idx_q <= tail.idx;
                nsum_q <= tail.fsum + 32'(dist_q);
                nhits_q <= tail.fhits + 16'd1;
                div_start <= 1'b1;
                state <= S_DIV;
              end else begin
                state <= S_IDLE;
              end
            end else if (32'(used_q[ring_q]) < CPR) begin
              wr_q.en <= 1'b1;
              wr_q.ring <= ring_q;
              wr_q.idx <= used_q[ring_q][rdmc_pkg::IDX_W-1:0];
              wr_q.sum <= 32'(dist_q);
              wr_q.hits <= 16'd1;
              wr_q.mean <= dist_q;
              used_q[ring_q] <= used_q[ring_q] + 1'b1;
              state <= S_IDLE;
            end else begin
              drop_q[ring_q] <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            wr_q.en <= 1'b1;
            wr_q.ring <= ring_q;
            wr_q.idx <= idx_q;
            wr_q.sum <= nsum_q;
            wr_q.hits <= nhits_q;
            wr_q.mean <= div_quo;
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (32'(ring_q) == RC - 1) begin
              drop_q <= '0;
              for (int i = 0; i < RC; i++) used_q[i] <= '0;
              state <= S_IDLE;
            end else begin
              ring_q <= ring_q + 3'd1;
              state <= S_LAUNCH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_out_only_busy, clk, rst, out_valid |-> in_stall)
  `ASSERT_CLK(a_no_write_in_walk, clk, rst, wr_q.en |-> !tail.valid)
  `ASSERT_CLK(a_used_bounded, clk, rst, 32'(used_q[ring_q]) <= CPR)
endmodule
